// File: hdl/arsr_pkg.sv
`default_nettype none

package arsr_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int COUNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int STAMP_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int OUT_SLOT_W  = 3;
    localparam int OUT_COUNT_W = 4;
    // common width for comparing a display index against a count
    localparam int IDXC_W      = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

    localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
    localparam logic [STAMP_W-1:0] STAMP_EMPTY = '0;
    localparam logic [STAMP_W-1:0] STAMP_FIRST = STAMP_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_SAVE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_RANGE   = 2'd1,
        STATUS_EXHAUST = 2'd2
    } arsr_status_t;

    typedef struct packed {
        arsr_status_t           status;
        logic [OUT_SLOT_W-1:0]  slot;
        logic                   evicted;
        logic [OUT_COUNT_W-1:0] filled_count;
    } arsr_result_t;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic [STAMP_W-1:0] data;
    } arsr_wr_t;

endpackage

`default_nettype wire

// File: hdl/arsr_slot_table.sv
`default_nettype none

module arsr_slot_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire arsr_pkg::arsr_wr_t           wr,
    input  wire logic [arsr_pkg::SLOT_W-1:0]  rd_addr,
    output logic      [arsr_pkg::STAMP_W-1:0] rd_data
);
    import arsr_pkg::*;

    logic [STAMP_W-1:0] stamp_reg [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                stamp_reg[i] <= STAMP_EMPTY;
            end
        end
        else if (wr.en)
        begin
            stamp_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = stamp_reg[rd_addr];

endmodule

`default_nettype wire

// File: hdl/arsr_cmp_unit.sv
`default_nettype none

// Shared magnitude comparator: every stamp ordering decision goes through here.
module arsr_cmp_unit (
    input  wire logic [arsr_pkg::STAMP_W-1:0] a,
    input  wire logic [arsr_pkg::STAMP_W-1:0] b,
    output logic                              gt
);
    import arsr_pkg::*;

    assign gt = (a > b);

endmodule

`default_nettype wire

// File: hdl/arsr_ctrl.sv
`default_nettype none

module arsr_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [arsr_pkg::FUNC_W-1:0]  func,
    input  wire logic [arsr_pkg::IDX_W-1:0]   display_index,
    input  wire logic                         out_free,
    output logic                              done,
    output arsr_pkg::arsr_result_t            result,
    output arsr_pkg::arsr_wr_t                wr,
    output logic      [arsr_pkg::SLOT_W-1:0]  rd_addr,
    input  wire logic [arsr_pkg::STAMP_W-1:0] rd_data,
    output logic      [arsr_pkg::STAMP_W-1:0] cmp_a,
    output logic      [arsr_pkg::STAMP_W-1:0] cmp_b,
    input  wire logic                         cmp_gt
);
    import arsr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SAVE  = 5'b00010,
        ST_RLOAD = 5'b00100,
        ST_RCNT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    state_t              state_reg,      state_next;
    logic [FUNC_W-1:0]   func_reg,       func_next;
    logic [IDX_W-1:0]    idx_reg,        idx_next;
    logic [SLOT_W-1:0]   ptr_reg,        ptr_next;
    logic [SLOT_W-1:0]   piv_reg,        piv_next;
    logic [STAMP_W-1:0]  pivot_reg,      pivot_next;
    logic [STAMP_W-1:0]  best_reg,       best_next;
    logic [SLOT_W-1:0]   best_idx_reg,   best_idx_next;
    logic [COUNT_W-1:0]  cnt_reg,        cnt_next;
    arsr_status_t        res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg,   res_slot_next;
    logic                res_evict_reg,  res_evict_next;
    logic [STAMP_W-1:0]  stamp_reg,      stamp_next;
    logic [COUNT_W-1:0]  filled_reg,     filled_next;

    logic               cur_zero;
    logic               ptr_last;
    logic               piv_last;
    logic               take;
    logic [COUNT_W-1:0] cnt_sum;

    assign cur_zero = (rd_data == STAMP_EMPTY);
    assign ptr_last = (ptr_reg == LAST_SLOT);
    assign piv_last = (piv_reg == LAST_SLOT);
    assign in_ready = (state_reg == ST_IDLE);
    assign take     = (ptr_reg == '0) || cmp_gt;
    assign cnt_sum  = cnt_reg + COUNT_W'(!cur_zero && cmp_gt);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        piv_next        = piv_reg;
        pivot_next      = pivot_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_evict_next  = res_evict_reg;
        stamp_next      = stamp_reg;
        filled_next     = filled_reg;
        done            = 1'b0;
        wr              = '{en: 1'b0, addr: res_slot_reg, data: STAMP_EMPTY};
        rd_addr         = ptr_reg;
        // save looks for a smaller stamp, rank counts newer stamps than the pivot
        cmp_a           = rd_data;
        cmp_b           = pivot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = func;
                    idx_next        = display_index;
                    ptr_next        = '0;
                    piv_next        = '0;
                    res_status_next = STATUS_OK;
                    res_slot_next   = '0;
                    res_evict_next  = 1'b0;
                    unique case (func)
                        FUNC_SAVE:
                        begin
                            if (stamp_reg == STAMP_MAX || stamp_reg == STAMP_EMPTY)
                            begin
                                res_status_next = STATUS_EXHAUST;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SAVE;
                            end
                        end
                        FUNC_DELETE, FUNC_LOCATE:
                        begin
                            if (IDXC_W'(display_index) >= IDXC_W'(filled_reg))
                            begin
                                res_status_next = STATUS_RANGE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RLOAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SAVE:
            begin
                cmp_a = best_reg;
                cmp_b = rd_data;
                if (cur_zero)
                begin
                    // lowest empty slot wins outright
                    res_slot_next = ptr_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    if (take)
                    begin
                        best_next     = rd_data;
                        best_idx_next = ptr_reg;
                    end
                    if (ptr_last)
                    begin
                        res_slot_next  = take ? ptr_reg : best_idx_reg;
                        res_evict_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end

            ST_RLOAD:
            begin
                rd_addr = piv_reg;
                if (cur_zero)
                begin
                    if (piv_last)
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        piv_next = piv_reg + 1'b1;
                    end
                end
                else
                begin
                    pivot_next = rd_data;
                    ptr_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_RCNT;
                end
            end

            ST_RCNT:
            begin
                if (ptr_last)
                begin
                    if (IDXC_W'(cnt_sum) == IDXC_W'(idx_reg))
                    begin
                        res_slot_next = piv_reg;
                        state_next    = ST_DONE;
                    end
                    else if (piv_last)
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        piv_next   = piv_reg + 1'b1;
                        state_next = ST_RLOAD;
                    end
                end
                else
                begin
                    cnt_next = cnt_sum;
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                    if (res_status_reg == STATUS_OK)
                    begin
                        if (func_reg == FUNC_SAVE)
                        begin
                            wr.en      = 1'b1;
                            wr.data    = stamp_reg;
                            stamp_next = stamp_reg + 1'b1;
                            if (!res_evict_reg)
                            begin
                                filled_next = filled_reg + 1'b1;
                            end
                        end
                        else if (func_reg == FUNC_DELETE)
                        begin
                            wr.en       = 1'b1;
                            filled_next = filled_reg - 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result = '{status:       res_status_reg,
                      slot:         OUT_SLOT_W'(res_slot_reg),
                      evicted:      res_evict_reg,
                      filled_count: OUT_COUNT_W'(filled_next)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stamp_reg      <= STAMP_FIRST;
            filled_reg     <= '0;
            res_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            stamp_reg      <= stamp_next;
            filled_reg     <= filled_next;
            res_status_reg <= res_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        idx_reg       <= idx_next;
        ptr_reg       <= ptr_next;
        piv_reg       <= piv_next;
        pivot_reg     <= pivot_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        cnt_reg       <= cnt_next;
        res_slot_reg  <= res_slot_next;
        res_evict_reg <= res_evict_next;
    end

endmodule

`default_nettype wire

// File: hdl/age_ranked_slot_replacer.sv
// Oldest-first slot replacer over a table of age-stamped slots.
// Input channel (in_valid/in_ready) carries one beat per command: func and
// display_index. Output channel (out_valid/out_ready) returns one beat per
// command: status, slot, evicted, filled_count.
// One command runs at a time; in_ready is high only while the sequencer idles.
// All stamp work goes through one 32-bit comparator, one slot per cycle:
//   save:           scans slots in order, stops at the first empty slot
//                   (at most 8 slots scanned)
//   delete, locate: counts newer stamps over all slots for each pivot slot;
//                   empty pivot slots are skipped without a counting pass
//   refused or unused command: goes straight to the result
// The next command is taken the cycle after the result is registered, so a
// new beat can be accepted while the previous result still waits at the
// output. If out_ready stays low, the finished command holds in its final
// state and the table is not updated until the output register frees up.
// Reset empties every slot, clears the filled count and sets the next stamp
// to one; no clearing pass is needed.
`default_nettype none

module age_ranked_slot_replacer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [arsr_pkg::FUNC_W-1:0]       func,
    input  wire logic [arsr_pkg::IDX_W-1:0]        display_index,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [arsr_pkg::STATUS_W-1:0]     status,
    output logic      [arsr_pkg::OUT_SLOT_W-1:0]   slot,
    output logic                                   evicted,
    output logic      [arsr_pkg::OUT_COUNT_W-1:0]  filled_count
);
    import arsr_pkg::*;

    arsr_wr_t           wr;
    arsr_result_t       result;
    arsr_result_t       out_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;
    logic               done;
    logic [SLOT_W-1:0]  rd_addr;
    logic [STAMP_W-1:0] rd_data;
    logic [STAMP_W-1:0] cmp_a;
    logic [STAMP_W-1:0] cmp_b;
    logic               cmp_gt;

    arsr_slot_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    arsr_cmp_unit u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .gt (cmp_gt)
    );

    arsr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .display_index (display_index),
        .out_free      (out_free),
        .done          (done),
        .result        (result),
        .wr            (wr),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .cmp_a         (cmp_a),
        .cmp_b         (cmp_b),
        .cmp_gt        (cmp_gt)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign slot         = out_reg.slot;
    assign evicted      = out_reg.evicted;
    assign filled_count = out_reg.filled_count;

endmodule

`default_nettype wire

// File: hdl/arsr_checker.sv
`default_nettype none

module arsr_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic [arsr_pkg::FUNC_W-1:0]       func,
    input wire logic [arsr_pkg::IDX_W-1:0]        display_index,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [arsr_pkg::STATUS_W-1:0]     status,
    input wire logic [arsr_pkg::OUT_SLOT_W-1:0]   slot,
    input wire logic                              evicted,
    input wire logic [arsr_pkg::OUT_COUNT_W-1:0]  filled_count
);
    import arsr_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
            && $stable(evicted) && $stable(filled_count))
        else $error("result beat changed while stalled");

    // an accepted command makes in_ready drop in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while a command was in flight");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> slot == '0 && evicted == 1'b0)
        else $error("failed command reported a slot or an eviction");

    // eviction only happens with every slot filled
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> filled_count == OUT_COUNT_W'(SLOT_COUNT))
        else $error("eviction reported with an empty slot left");

endmodule

bind age_ranked_slot_replacer arsr_checker u_arsr_checker (.*);

`default_nettype wire

// File: bench/age_ranked_slot_replacer_tb.sv
`timescale 1ns / 100ps

module age_ranked_slot_replacer_tb;

    import arsr_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_CMDS  = 1030;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 160;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 80;

    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [IDX_W-1:0]  idx;
        int unsigned       gap;
        bit                drain;
    } cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func = FUNC_SAVE;
    logic [IDX_W-1:0]       display_index = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [OUT_SLOT_W-1:0]  slot;
    logic                   evicted;
    logic [OUT_COUNT_W-1:0] filled_count;

    // predictor state
    logic [STAMP_W-1:0] stamp_tbl [SLOT_COUNT];
    logic [STAMP_W-1:0] next_stamp;

    cmd_t         cmd_backlog[$];
    arsr_result_t pending_results[$];
    int unsigned  cmds_issued = 0;
    int unsigned  results_taken = 0;
    int unsigned  gap_waited = 0;
    int unsigned  hold_left = 0;
    int unsigned  idle_cycles = 0;
    bit           mismatch_seen = 1'b0;

    age_ranked_slot_replacer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .display_index (display_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .slot          (slot),
        .evicted       (evicted),
        .filled_count  (filled_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int count_filled();
        int n;
        n = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            if (stamp_tbl[s] != STAMP_EMPTY)
                n++;
        end
        return n;
    endfunction

    // Apply one command to the slot table and return the beat it should produce.
    function automatic arsr_result_t predict_slot_result(logic [FUNC_W-1:0] op,
                                                         logic [IDX_W-1:0] idx);
        arsr_result_t res;
        int pick;
        int rank;
        res = '0;
        res.status = STATUS_OK;
        pick = -1;
        if (op == FUNC_SAVE)
        begin
            if (next_stamp == STAMP_MAX || next_stamp == STAMP_EMPTY)
                res.status = STATUS_EXHAUST;
            else
            begin
                for (int s = 0; s < SLOT_COUNT; s++)
                begin
                    if (pick < 0 && stamp_tbl[s] == STAMP_EMPTY)
                        pick = s;
                end
                // table full: take the oldest, lowest index on ties
                if (pick < 0)
                begin
                    pick = 0;
                    for (int s = 1; s < SLOT_COUNT; s++)
                    begin
                        if (stamp_tbl[s] < stamp_tbl[pick])
                            pick = s;
                    end
                end
                res.slot = OUT_SLOT_W'(pick);
                res.evicted = (stamp_tbl[pick] != STAMP_EMPTY);
                stamp_tbl[pick] = next_stamp;
                next_stamp = next_stamp + 1'b1;
            end
        end
        else if (op == FUNC_DELETE || op == FUNC_LOCATE)
        begin
            if (int'(idx) < count_filled())
            begin
                for (int s = 0; s < SLOT_COUNT; s++)
                begin
                    if (stamp_tbl[s] != STAMP_EMPTY && pick < 0)
                    begin
                        rank = 0;
                        for (int t = 0; t < SLOT_COUNT; t++)
                        begin
                            if (t != s && stamp_tbl[t] != STAMP_EMPTY &&
                                (stamp_tbl[t] > stamp_tbl[s] ||
                                 (stamp_tbl[t] == stamp_tbl[s] && t < s)))
                                rank++;
                        end
                        if (rank == int'(idx))
                            pick = s;
                    end
                end
            end
            if (pick < 0)
                res.status = STATUS_RANGE;
            else
            begin
                res.slot = OUT_SLOT_W'(pick);
                if (op == FUNC_DELETE)
                    stamp_tbl[pick] = STAMP_EMPTY;
            end
        end
        res.filled_count = OUT_COUNT_W'(count_filled());
        return res;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    task automatic queue_cmd(logic [FUNC_W-1:0] op, logic [IDX_W-1:0] idx, bit drain);
        cmd_t c;
        c.op = op;
        c.idx = idx;
        c.gap = $urandom_range(0, MAX_GAP);
        c.drain = drain;
        cmd_backlog.push_back(c);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit   took;
        bit   free;
        bit   send;
        cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_SAVE;
            display_index <= '0;
            gap_waited <= 0;
            cmds_issued <= 0;
            for (int s = 0; s < SLOT_COUNT; s++)
                stamp_tbl[s] = STAMP_EMPTY;
            next_stamp = STAMP_FIRST;
        end
        else
        begin
            took = in_valid && in_ready;
            free = !in_valid || took;
            send = 1'b0;
            if (took)
            begin
                pending_results.push_back(predict_slot_result(func, display_index));
                cmds_issued <= cmds_issued + 1;
            end
            if (free && cmd_backlog.size() > 0)
            begin
                // hold a draining beat until every result is back
                if (cmd_backlog[0].drain && cmds_issued + took != results_taken)
                    send = 1'b0;
                else if (gap_waited < cmd_backlog[0].gap)
                    gap_waited <= gap_waited + 1;
                else
                begin
                    nxt = cmd_backlog.pop_front();
                    func <= nxt.op;
                    display_index <= nxt.idx;
                    gap_waited <= 0;
                    send = 1'b1;
                end
            end
            in_valid <= send || !free;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : monitor
        arsr_result_t want;
        int unsigned  wait_cycles;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            results_taken <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (results_taken == cmds_issued)
            begin
                $display("%0t: result beat with nothing expected: status %0d slot %0d",
                         $time, status, slot);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, status);
                check_field("slot", want.slot, slot);
                check_field("evicted", want.evicted, evicted);
                check_field("filled_count", want.filled_count, filled_count);
                results_taken <= results_taken + 1;
            end
            if (results_taken == 199 || results_taken == 599)
                wait_cycles = LONG_HOLD;
            else if ((results_taken / 50) % 4 == 1)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, MAX_GAP);
            out_ready <= (wait_cycles == 0);
            hold_left <= wait_cycles;
        end
        else if (!out_ready)
        begin
            if (hold_left <= 1)
            begin
                out_ready <= 1'b1;
                hold_left <= 0;
            end
            else
                hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned      r;
        int unsigned      save_pct;
        bit               quiet;
        logic [FUNC_W-1:0] op;

        // empty table: out-of-range lookups and the unused code
        queue_cmd(FUNC_LOCATE, 3'd0, 1'b0);
        queue_cmd(FUNC_DELETE, 3'd7, 1'b0);
        queue_cmd(FUNC_UNUSED, 3'd0, 1'b0);
        // fill every slot, then wrap into eviction of the oldest
        for (int i = 0; i < SLOT_COUNT + 2; i++)
            queue_cmd(FUNC_SAVE, 3'(i), 1'b0);
        queue_cmd(FUNC_LOCATE, 3'd0, 1'b0);
        queue_cmd(FUNC_LOCATE, 3'd7, 1'b0);
        queue_cmd(FUNC_LOCATE, 3'd4, 1'b0);
        queue_cmd(FUNC_DELETE, 3'd7, 1'b0);
        queue_cmd(FUNC_DELETE, 3'd0, 1'b0);
        queue_cmd(FUNC_DELETE, 3'd3, 1'b0);
        queue_cmd(FUNC_LOCATE, 3'd7, 1'b0);
        queue_cmd(FUNC_UNUSED, 3'd7, 1'b0);
        // refill a hole, then hit the last valid rank
        queue_cmd(FUNC_SAVE, 3'd5, 1'b0);
        queue_cmd(FUNC_DELETE, 3'd5, 1'b0);

        save_pct = 50;
        quiet = 1'b0;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            // drift between filling and draining phases
            if (n % 48 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                save_pct = $urandom_range(15, 85);
            end
            r = $urandom_range(0, 99);
            if (r < save_pct)
                op = FUNC_SAVE;
            else if (r < 97)
                op = $urandom_range(0, 1) ? FUNC_DELETE : FUNC_LOCATE;
            else
                op = FUNC_UNUSED;
            queue_cmd(op, 3'($urandom_range(0, 7)), n == 0 || n == 350 || n == 700);
            if (quiet)
                cmd_backlog[$].gap = 0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || in_valid || results_taken != cmds_issued)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!mismatch_seen)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: age_ranked_slot_replacer.f
hdl/arsr_pkg.sv
hdl/arsr_slot_table.sv
hdl/arsr_cmp_unit.sv
hdl/arsr_ctrl.sv
hdl/age_ranked_slot_replacer.sv
hdl/arsr_checker.sv
bench/age_ranked_slot_replacer_tb.sv
